### hw/rtl/ndd_pkg.sv
// ----------------------------------------------------------------------------
// ndd_pkg
// Shared types and constants for the Newton divided-difference block.
// ----------------------------------------------------------------------------
package ndd_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_REP  = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic               start_req;
        logic signed [31:0] position;
        logic signed [31:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic [5:0]         order;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SETUP,
        S_DIV,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

### hw/rtl/newton_divided_difference_top.sv
// ----------------------------------------------------------------------------
// newton_divided_difference_top
// Incremental Newton divided differences with one shared radix-2 divider.
// ----------------------------------------------------------------------------
// Point k of a set takes k divisions in one shared restoring divider, each
// over 33 + FRAC_BITS quotient bits, with the states of memory read, setup
// and write back around it. A zero divisor skips the iterations. The S_OUT
// state then presents the result. The first point of a set and a point past
// a full store are answered from S_IDLE directly. The input is stalled
// while an item is in work or its result waits to be taken.
module newton_divided_difference_top #(
    parameter int MAX_POINTS = ndd_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = ndd_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ndd_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output ndd_pkg::t_out_item o_item
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NW = 33 + FRAC_BITS;     // dividend magnitude width
    localparam int DW = 33;                  // divisor magnitude width
    localparam int BW = $clog2(NW + 1);

    // storage
    logic signed [31:0] r_pos_mem [MAX_POINTS];
    logic signed [31:0] r_diag_mem[MAX_POINTS];

    ndd_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_d, n_d;
    logic signed [31:0] r_pos, n_pos;
    logic signed [31:0] r_upper, n_upper;   // diagonal[d+1]
    logic signed [31:0] r_rd_diag, r_rd_pos;
    logic [1:0] r_status, n_status;
    logic r_valid, n_valid;
    ndd_pkg::t_out_item r_out, n_out;
    // divider
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_dm, n_dm;
    logic [BW-1:0] r_bit, n_bit;
    logic r_neg, n_neg;
    logic r_zero, n_zero;
    logic r_nsign, n_nsign;
    logic r_nz, n_nz;

    logic signed [32:0] num_w, den_w;
    logic [DW:0] rem_sh;
    logic [DW:0] rem_sub;
    logic signed [31:0] quot;
    logic [1:0] qflag;
    logic wr_en;
    logic [IW-1:0] wr_idx;
    logic signed [31:0] wr_data;
    logic pos_we;
    logic [IW-1:0] rd_idx;

    assign o_stall = (r_state != ndd_pkg::S_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_item  = r_out;

    assign num_w  = 33'(r_upper) - 33'(r_rd_diag);
    assign den_w  = 33'(r_pos) - 33'(r_rd_pos);
    assign rem_sh = {r_rem[DW-1:0], r_q[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dm};

    // saturate quotient, or replace it when the divisor is zero
    always_comb begin
        qflag = ndd_pkg::ST_OK;
        quot  = '0;
        if (r_zero) begin
            qflag = ndd_pkg::ST_REP;
            if (!r_nz) quot = '0;
            else if (r_nsign) quot = 32'sh8000_0000;
            else quot = 32'sh7fff_ffff;
        end else if (r_neg) begin
            if (r_q > NW'(33'h0_8000_0000)) begin
                qflag = ndd_pkg::ST_SAT;
                quot = 32'sh8000_0000;
            end else begin
                quot = 32'(-r_q[32:0]);
            end
        end else begin
            if (r_q > NW'(33'h0_7fff_ffff)) begin
                qflag = ndd_pkg::ST_SAT;
                quot = 32'sh7fff_ffff;
            end else begin
                quot = r_q[31:0];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_k = r_k; n_d = r_d; n_pos = r_pos;
        n_upper = r_upper; n_status = r_status; n_valid = r_valid; n_out = r_out;
        n_q = r_q; n_rem = r_rem; n_dm = r_dm; n_bit = r_bit; n_neg = r_neg;
        n_zero = r_zero; n_nsign = r_nsign; n_nz = r_nz;
        wr_en = 1'b0; wr_idx = r_k; wr_data = i_item.sample; pos_we = 1'b0;
        rd_idx = r_d;
        if (r_valid && !i_stall) n_valid = 1'b0;
        unique case (r_state)
            ndd_pkg::S_IDLE: begin
                if (i_valid && !o_stall) begin
                    if (i_item.start_req || r_cnt == '0) begin
                        n_k = '0;
                        n_cnt = CW'(1);
                        wr_en = 1'b1; pos_we = 1'b1; wr_idx = '0;
                        n_out = '{coefficient: i_item.sample, order: '0,
                                  status: ndd_pkg::ST_OK};
                        n_valid = 1'b1;
                    end else if (r_cnt == CW'(MAX_POINTS)) begin
                        n_out = '{coefficient: '0, order: '0,
                                  status: ndd_pkg::ST_FULL};
                        n_valid = 1'b1;
                    end else begin
                        n_k = r_cnt[IW-1:0];
                        n_cnt = r_cnt + CW'(1);
                        wr_en = 1'b1; pos_we = 1'b1; wr_idx = r_cnt[IW-1:0];
                        n_pos = i_item.position;
                        n_upper = i_item.sample;
                        n_d = r_cnt[IW-1:0] - IW'(1);
                        n_status = ndd_pkg::ST_OK;
                        n_state = ndd_pkg::S_READ;
                    end
                end
            end
            ndd_pkg::S_READ: n_state = ndd_pkg::S_SETUP;
            ndd_pkg::S_SETUP: begin
                n_zero  = (den_w == '0);
                n_nz    = (num_w != '0);
                n_nsign = num_w[32];
                n_neg   = num_w[32] ^ den_w[32];
                n_q     = NW'(num_w[32] ? 33'(-num_w) : 33'(num_w)) << FRAC_BITS;
                n_dm    = den_w[32] ? 33'(-den_w) : 33'(den_w);
                n_rem   = '0;
                n_bit   = BW'(NW);
                n_state = den_w == '0 ? ndd_pkg::S_WRITE : ndd_pkg::S_DIV;
            end
            ndd_pkg::S_DIV: begin
                if (!rem_sub[DW]) begin
                    n_rem = rem_sub;
                    n_q = {r_q[NW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_q = {r_q[NW-2:0], 1'b0};
                end
                n_bit = r_bit - BW'(1);
                if (r_bit == BW'(1)) n_state = ndd_pkg::S_WRITE;
            end
            ndd_pkg::S_WRITE: begin
                wr_en = 1'b1; wr_idx = r_d; wr_data = quot;
                n_upper = quot;
                if (qflag == ndd_pkg::ST_REP) n_status = ndd_pkg::ST_REP;
                else if (qflag == ndd_pkg::ST_SAT && r_status == ndd_pkg::ST_OK)
                    n_status = ndd_pkg::ST_SAT;
                if (r_d == '0) begin
                    n_state = ndd_pkg::S_OUT;
                end else begin
                    n_d = r_d - IW'(1);
                    rd_idx = r_d - IW'(1);
                    n_state = ndd_pkg::S_READ;
                end
            end
            ndd_pkg::S_OUT: begin
                n_out = '{coefficient: r_upper, order: 6'(r_k), status: r_status};
                n_valid = 1'b1;
                n_state = ndd_pkg::S_IDLE;
            end
            default: n_state = ndd_pkg::S_IDLE;
        endcase
    end

    // memories: one write port each, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_diag_mem[wr_idx] <= wr_data;
        if (pos_we) r_pos_mem[wr_idx] <= i_item.position;
        r_rd_diag <= r_diag_mem[rd_idx];
        r_rd_pos  <= r_pos_mem[rd_idx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ndd_pkg::S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_d <= n_d; r_pos <= n_pos; r_upper <= n_upper;
        r_status <= n_status; r_out <= n_out; r_q <= n_q; r_rem <= n_rem;
        r_dm <= n_dm; r_bit <= n_bit; r_neg <= n_neg; r_zero <= n_zero;
        r_nsign <= n_nsign; r_nz <= n_nz;
    end

endmodule

### hw/rtl/ndd_checker.sv
// ----------------------------------------------------------------------------
// ndd_checker
// Port-level checks for the Newton divided-difference block.
// ----------------------------------------------------------------------------
module ndd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input ndd_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_stall,
    input ndd_pkg::t_out_item o_item
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed under stall");

    // no new item taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open with pending result");

    // a start item yields order zero at once
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.start_req |=>
            o_valid && o_item.order == '0 && o_item.status == ndd_pkg::ST_OK)
        else $error("start item result wrong");

    // full status always carries a zero coefficient and order zero
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ndd_pkg::ST_FULL |->
            o_item.coefficient == '0 && o_item.order == '0)
        else $error("full result not cleared");

endmodule

bind newton_divided_difference_top ndd_checker u_ndd_checker (.*);
